// File: hdl/frs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_pkg: shared types for the frequency residency statistics block
// Operation codes and the command and status groups that pass between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package frs_pkg;

    localparam int OP_W = 3;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD     = 3'd0,
        OP_START    = 3'd1,
        OP_MOVE     = 3'd2,
        OP_READ_RES = 3'd3,
        OP_READ_CNT = 3'd4
    } t_op;

    // One command per controller phase.
    typedef struct packed {
        logic clear;
        logic capture;
        logic lookup;
        logic exec;
        logic fetch;
        logic finish;
    } t_ctl_cmd;

    typedef struct packed {
        logic clear_last;
    } t_ctl_sts;

endpackage

// File: hdl/frs_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_ctrl: sequencing controller
// Runs the memory clearing pass after reset, then steps each accepted beat
// through lookup, execute, fetch and finish.
// ----------------------------------------------------------------------------
module frs_ctrl
    import frs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd,
    output logic     busy
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_EXEC,
        ST_FETCH,
        ST_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_busy, n_busy;

    always_comb begin
        n_state = r_state;
        n_busy  = r_busy;
        o_cmd   = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clear_last) begin
                    n_state = ST_IDLE;
                    n_busy  = 1'b0;
                end
            end
            ST_IDLE: begin
                if (start && !r_busy) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_LOOK;
                    n_busy        = 1'b1;
                end
            end
            ST_LOOK: begin
                o_cmd.lookup = 1'b1;
                n_state      = ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = ST_FETCH;
            end
            ST_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = ST_FIN;
            end
            ST_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
                n_busy       = 1'b0;
            end
            default: begin
                n_state = ST_IDLE;
                n_busy  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_busy  <= n_busy;
        end
    end

    assign busy = r_busy;

endmodule

// File: hdl/frs_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frs_dpath: statistics datapath
// Holds the frequency table, the residency and transition memories, the
// time stamp and counters, and the registered result.
// ----------------------------------------------------------------------------
module frs_dpath
    import frs_pkg::*;
#(
    parameter int NUM_STATES = 16,
    parameter int IDX_W      = $clog2(NUM_STATES),
    parameter int CNT_W      = $clog2(NUM_STATES + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctl_cmd         i_cmd,
    output t_ctl_sts         o_sts,
    input  logic [OP_W-1:0]  i_operation,
    input  logic [31:0]      i_freq_khz,
    input  logic [63:0]      i_now,
    input  logic [IDX_W-1:0] i_from_index,
    input  logic [IDX_W-1:0] i_to_index,
    output logic             o_valid,
    output logic [63:0]      o_value,
    output logic             o_ok,
    output logic [CNT_W-1:0] o_current_index,
    output logic [CNT_W-1:0] o_states_in_use,
    output logic [31:0]      o_total_transitions
);

    localparam int MAT_W     = 2 * IDX_W;
    localparam int RES_DEPTH = 1 << IDX_W;
    localparam int MAT_DEPTH = 1 << MAT_W;

    // Captured beat.
    t_op              r_op;
    logic [31:0]      r_freq;
    logic [63:0]      r_now;
    logic [IDX_W-1:0] r_from;
    logic [IDX_W-1:0] r_to;

    // Architectural state.
    logic [31:0]      r_table [NUM_STATES];
    logic [CNT_W-1:0] r_state;
    logic [CNT_W-1:0] r_count;
    logic [63:0]      r_stamp;
    logic [31:0]      r_total;

    // Working registers.
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_idx;
    logic [63:0]      r_elapsed;
    logic             r_ok;
    logic             r_do_inc;
    logic [MAT_W-1:0] r_maddr;
    logic [MAT_W-1:0] r_clr;

    // Memories.
    logic [63:0] r_res [RES_DEPTH];
    logic [31:0] r_mat [MAT_DEPTH];
    logic [63:0] r_res_rd;
    logic [31:0] r_mat_rd;

    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic             known;
    logic [IDX_W-1:0] cur;
    logic             move_ok;
    logic             from_ok;
    logic             to_ok;

    // Parallel search of the loaded entries; the lowest match wins.
    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_STATES - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < r_count) && (r_table[i] == r_freq)) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign known   = r_state < CNT_W'(NUM_STATES);
    assign cur     = r_state[IDX_W-1:0];
    assign move_ok = known && r_hit && (r_hit_idx != cur);
    assign from_ok = CNT_W'(r_from) < r_count;
    assign to_ok   = CNT_W'(r_to) < r_count;

    assign o_sts.clear_last = (r_clr == {MAT_W{1'b1}});

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= CNT_W'(NUM_STATES);
            r_count  <= '0;
            r_stamp  <= '0;
            r_total  <= '0;
            r_clr    <= '0;
            r_do_inc <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= i_cmd.finish;
            if (i_cmd.clear) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.exec) begin
                r_do_inc <= 1'b0;
                case (r_op)
                    OP_LOAD: begin
                        if ((r_count < CNT_W'(NUM_STATES)) && !r_hit) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                    OP_START: begin
                        r_stamp <= r_now;
                        r_state <= r_hit ? CNT_W'(r_hit_idx) : CNT_W'(NUM_STATES);
                    end
                    OP_MOVE: begin
                        if (move_ok) begin
                            r_stamp  <= r_now;
                            r_state  <= CNT_W'(r_hit_idx);
                            r_total  <= r_total + 1'b1;
                            r_do_inc <= 1'b1;
                        end
                    end
                    OP_READ_RES: begin
                        r_stamp <= r_now;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op   <= t_op'(i_operation);
            r_freq <= i_freq_khz;
            r_now  <= i_now;
            r_from <= i_from_index;
            r_to   <= i_to_index;
        end
        if (i_cmd.lookup) begin
            r_hit     <= hit;
            r_hit_idx <= hit_idx;
            r_elapsed <= r_now - r_stamp;
        end
        if (i_cmd.exec) begin
            r_maddr <= (r_op == OP_MOVE) ? {cur, r_hit_idx} : {r_from, r_to};
            case (r_op)
                OP_LOAD: begin
                    r_ok <= (r_count < CNT_W'(NUM_STATES)) && !r_hit;
                    if ((r_count < CNT_W'(NUM_STATES)) && !r_hit) begin
                        r_table[r_count[IDX_W-1:0]] <= r_freq;
                    end
                end
                OP_START:    r_ok <= 1'b1;
                OP_MOVE:     r_ok <= move_ok;
                OP_READ_RES: r_ok <= from_ok;
                OP_READ_CNT: r_ok <= from_ok && to_ok;
                default:     r_ok <= 1'b0;
            endcase
        end
        if (i_cmd.finish) begin
            o_ok <= r_ok;
            if (r_ok && (r_op == OP_READ_RES)) begin
                o_value <= r_res_rd;
            end else if (r_ok && (r_op == OP_READ_CNT)) begin
                o_value <= {32'd0, r_mat_rd};
            end else begin
                o_value <= '0;
            end
        end
    end

    // Residency memory: the current state is read in lookup and written back
    // in execute; the requested entry is read in fetch.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_res[r_clr[IDX_W-1:0]] <= '0;
        end else if (i_cmd.exec && known &&
                     ((r_op == OP_READ_RES) || ((r_op == OP_MOVE) && move_ok))) begin
            r_res[cur] <= r_res_rd + r_elapsed;
        end
        if (i_cmd.lookup) begin
            r_res_rd <= r_res[cur];
        end else if (i_cmd.fetch) begin
            r_res_rd <= r_res[r_from];
        end
    end

    // Transition memory: read in fetch, incremented in finish.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_mat[r_clr] <= '0;
        end else if (i_cmd.finish && r_do_inc) begin
            r_mat[r_maddr] <= r_mat_rd + 1'b1;
        end
        if (i_cmd.fetch) begin
            r_mat_rd <= r_mat[r_maddr];
        end
    end

    assign o_current_index     = r_state;
    assign o_states_in_use     = r_count;
    assign o_total_transitions = r_total;

endmodule

// File: hdl/frequency_residency_stats_top.sv
`timescale 1ns / 1ps
// Each accepted beat is stepped through lookup, execute, fetch and finish in turn,
// and its result strobe is registered from the finish phase. The controller works
// on the residency and transition memories and takes a new beat only once idle.
// Reset: after the synchronous reset, busy stays high while both memories are swept
// to zero, through every entry of the transition memory.
// The receiver cannot stall: each result is shown for one cycle only.
// ----------------------------------------------------------------------------
// frequency_residency_stats_top: frequency residency statistics
// Keeps a table of operating frequencies, the time spent at each and a matrix
// of transition counts, and answers one result per command beat.
// ----------------------------------------------------------------------------
module frequency_residency_stats_top
    import frs_pkg::*;
#(
    parameter int NUM_STATES = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [OP_W-1:0]                     i_operation,
    input  logic [31:0]                         i_freq_khz,
    input  logic [63:0]                         i_now,
    input  logic [$clog2(NUM_STATES)-1:0]       i_from_index,
    input  logic [$clog2(NUM_STATES)-1:0]       i_to_index,
    output logic                                o_valid,
    output logic [63:0]                         o_value,
    output logic                                o_ok,
    output logic [$clog2(NUM_STATES + 1)-1:0]   o_current_index,
    output logic [$clog2(NUM_STATES + 1)-1:0]   o_states_in_use,
    output logic [31:0]                         o_total_transitions
);

    localparam int IDX_W = $clog2(NUM_STATES);
    localparam int CNT_W = $clog2(NUM_STATES + 1);

    // The controller only sequences; all statistics state lives in the datapath,
    // which it drives through one command group with a command for each phase.
    t_ctl_cmd cmd;
    t_ctl_sts sts;

    frs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    frs_dpath #(
        .NUM_STATES (NUM_STATES),
        .IDX_W      (IDX_W),
        .CNT_W      (CNT_W)
    ) u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_sts               (sts),
        .i_operation         (i_operation),
        .i_freq_khz          (i_freq_khz),
        .i_now               (i_now),
        .i_from_index        (i_from_index),
        .i_to_index          (i_to_index),
        .o_valid             (o_valid),
        .o_value             (o_value),
        .o_ok                (o_ok),
        .o_current_index     (o_current_index),
        .o_states_in_use     (o_states_in_use),
        .o_total_transitions (o_total_transitions)
    );

    // A result strobe never lasts more than one cycle.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // An accepted beat keeps the block busy in the following cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a beat");

    // A result follows the finish phase of a beat in progress.
    a_result_from_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(cmd.finish))
        else $error("result strobe without a finished beat");

    // The state index and entry count never leave their range.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_current_index <= CNT_W'(NUM_STATES)) &&
        (o_states_in_use <= CNT_W'(NUM_STATES)))
        else $error("state index or entry count out of range");

endmodule

// File: tb/frequency_residency_stats_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frequency_residency_stats_top_test: self-checking bench for the residency
// statistics block
// Directed tasks cover the empty table, loads with extreme values and a duplicate,
// refused and accepted transitions, reads in and out of range, timestamp wrap and the
// unused operation codes. A long random phase follows, in which transitions are the
// commonest beat, most of them between known frequencies. Every result is checked
// field by field against a prediction kept inside this bench.
// ----------------------------------------------------------------------------
module frequency_residency_stats_top_test
    import frs_pkg::*;
();

    localparam int NSTATES = 16;
    localparam int UNKNOWN = NSTATES;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 10;
    localparam int RANDOM_BEATS = 380;

    // Codes the block must ignore.
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

    typedef struct packed {
        logic [63:0] value;
        logic        ok;
        logic [4:0]  cur_state;
        logic [4:0]  used_states;
        logic [31:0] change_count;
    } t_status;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [OP_W-1:0] i_operation;
    logic [31:0] i_freq_khz;
    logic [63:0] i_now;
    logic [3:0]  i_from_index;
    logic [3:0]  i_to_index;
    logic        o_valid;
    logic [63:0] o_value;
    logic        o_ok;
    logic [4:0]  o_current_index;
    logic [4:0]  o_states_in_use;
    logic [31:0] o_total_transitions;

    frequency_residency_stats_top #(.NUM_STATES(NSTATES)) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_operation        (i_operation),
        .i_freq_khz         (i_freq_khz),
        .i_now              (i_now),
        .i_from_index       (i_from_index),
        .i_to_index         (i_to_index),
        .o_valid            (o_valid),
        .o_value            (o_value),
        .o_ok               (o_ok),
        .o_current_index    (o_current_index),
        .o_states_in_use    (o_states_in_use),
        .o_total_transitions(o_total_transitions)
    );

    // Shadow copy of the block's statistics.
    logic [31:0] freq_tab [NSTATES];
    logic [63:0] dwell_ticks [NSTATES];
    logic [31:0] switch_counts [NSTATES][NSTATES];
    logic [4:0]  cur_state;
    logic [63:0] last_stamp;
    logic [4:0]  used_states;
    logic [31:0] change_count;

    t_status     pending_status[$];
    int          errors;
    int          beats_sent;
    int          results_seen;
    int          cycles;
    int          burst_left;
    logic [63:0] clock_ticks;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The run is cut off here if the block ever stops answering.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycles, pending_status.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic [4:0] lookup_freq(input logic [31:0] f);
        for (int k = 0; k < used_states; k++) begin
            if (freq_tab[k] == f) return 5'(k);
        end
        return 5'(UNKNOWN);
    endfunction

    // Fold the time since the last stamp into the current state, if known.
    task automatic settle_dwell(input logic [63:0] stamp);
        if (cur_state < UNKNOWN) dwell_ticks[cur_state] += stamp - last_stamp;
        last_stamp = stamp;
    endtask

    // Apply one accepted beat to the shadow state and queue its result.
    task automatic predict_status(input logic [OP_W-1:0] op, input logic [31:0] f,
                                  input logic [63:0] stamp, input logic [3:0] row,
                                  input logic [3:0] col);
        t_status    r;
        logic [4:0] prev;
        logic [4:0] nxt;
        r = '0;
        case (op)
            OP_LOAD: begin
                if (used_states < NSTATES && lookup_freq(f) == UNKNOWN) begin
                    freq_tab[used_states] = f;
                    used_states++;
                    r.ok = 1'b1;
                end
            end
            OP_START: begin
                last_stamp = stamp;
                cur_state = lookup_freq(f);
                r.ok = 1'b1;
            end
            OP_MOVE: begin
                prev = cur_state;
                nxt = lookup_freq(f);
                if (prev < UNKNOWN && nxt < UNKNOWN && prev != nxt) begin
                    settle_dwell(stamp);
                    cur_state = nxt;
                    switch_counts[prev][nxt]++;
                    change_count++;
                    r.ok = 1'b1;
                end
            end
            OP_READ_RES: begin
                settle_dwell(stamp);
                if (row < used_states) begin
                    r.value = dwell_ticks[row];
                    r.ok = 1'b1;
                end
            end
            OP_READ_CNT: begin
                if (row < used_states && col < used_states) begin
                    r.value = 64'(switch_counts[row][col]);
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.cur_state = cur_state;
        r.used_states = used_states;
        r.change_count = change_count;
        pending_status.push_back(r);
    endtask

    // Drive one beat and hold it until the block takes it. The caller is
    // right after a rising edge, so start is raised at most once per step.
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [31:0] f,
                             input logic [63:0] stamp, input logic [3:0] row,
                             input logic [3:0] col);
        start <= 1'b1;
        i_operation <= op;
        i_freq_khz <= f;
        i_now <= stamp;
        i_from_index <= row;
        i_to_index <= col;
        do @(posedge i_clk); while (busy);
        predict_status(op, f, stamp, row, col);
        beats_sent++;
        // Bursts of back-to-back beats separated by random gaps; some gaps
        // are long enough to land on every phase of the controller.
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    // Timestamps mostly creep forward; now and then one jumps anywhere.
    function automatic logic [63:0] next_stamp();
        if ($urandom_range(0, 15) == 0) clock_ticks = {$urandom, $urandom};
        else clock_ticks += $urandom_range(1, 5000);
        return clock_ticks;
    endfunction

    function automatic logic [31:0] pick_freq();
        if (used_states > 0 && $urandom_range(0, 9) < 8)
            return freq_tab[$urandom_range(0, used_states - 1)];
        return $urandom;
    endfunction

    // Results come one cycle wide and cannot be held off: check each one
    // against the oldest outstanding prediction.
    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_status.size() == 0) begin
                $error("Result beat with no prediction outstanding.");
                errors++;
            end else begin
                want = pending_status.pop_front();
                if (o_value !== want.value) begin
                    $error("value: expected %0h, got %0h", want.value, o_value);
                    errors++;
                end
                if (o_ok !== want.ok) begin
                    $error("ok: expected %0d, got %0d", want.ok, o_ok);
                    errors++;
                end
                if (o_current_index !== want.cur_state) begin
                    $error("current_index: expected %0d, got %0d",
                           want.cur_state, o_current_index);
                    errors++;
                end
                if (o_states_in_use !== want.used_states) begin
                    $error("states_in_use: expected %0d, got %0d",
                           want.used_states, o_states_in_use);
                    errors++;
                end
                if (o_total_transitions !== want.change_count) begin
                    $error("total_transitions: expected %0d, got %0d",
                           want.change_count, o_total_transitions);
                    errors++;
                end
            end
        end
    end

    // Before anything is loaded every read and transition must be refused.
    task automatic test_empty_table();
        send_beat(OP_READ_RES, 32'd0, 64'd100, 4'd0, 4'd0);
        send_beat(OP_READ_CNT, 32'd0, 64'd0, 4'd0, 4'd0);
        send_beat(OP_MOVE, 32'd1000, 64'd200, 4'd0, 4'd0);
        send_beat(OP_START, 32'd1000, 64'd300, 4'd0, 4'd0);
    endtask

    // Extreme frequencies, a duplicate, and a start at an unknown frequency.
    task automatic test_load();
        send_beat(OP_LOAD, 32'd0, 64'd0, 4'd0, 4'd0);
        send_beat(OP_LOAD, 32'hFFFF_FFFF, 64'd0, 4'd0, 4'd0);
        send_beat(OP_LOAD, 32'd800000, 64'd0, 4'd0, 4'd0);
        send_beat(OP_LOAD, 32'hFFFF_FFFF, 64'd0, 4'd0, 4'd0);
        send_beat(OP_START, 32'd12345, 64'd500, 4'd0, 4'd0);
        send_beat(OP_READ_RES, 32'd0, 64'd900, 4'd0, 4'd0);
    endtask

    // Accepted moves, a move to the same frequency, and one across a
    // timestamp that has wrapped below the last stamp.
    task automatic test_moves();
        send_beat(OP_START, 32'd0, 64'd1000, 4'd0, 4'd0);
        send_beat(OP_MOVE, 32'hFFFF_FFFF, 64'd1500, 4'd0, 4'd0);
        send_beat(OP_MOVE, 32'hFFFF_FFFF, 64'd1700, 4'd0, 4'd0);
        send_beat(OP_MOVE, 32'd777, 64'd1800, 4'd0, 4'd0);
        send_beat(OP_MOVE, 32'd800000, 64'd40, 4'd0, 4'd0);
        send_beat(OP_MOVE, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 4'd0);
    endtask

    // Reads in range and past the loaded count, with all index bits set.
    task automatic test_reads();
        send_beat(OP_READ_RES, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 4'd0);
        send_beat(OP_READ_RES, 32'd0, 64'd5, 4'd15, 4'd0);
        send_beat(OP_READ_CNT, 32'd0, 64'd0, 4'd1, 4'd2);
        send_beat(OP_READ_CNT, 32'd0, 64'd0, 4'd0, 4'd15);
        send_beat(OP_READ_CNT, 32'd0, 64'd0, 4'd15, 4'd1);
    endtask

    task automatic test_unused_ops();
        send_beat(OP_SPARE_A, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 4'd15);
        send_beat(OP_SPARE_B, 32'd42, 64'd7, 4'd0, 4'd0);
        send_beat(OP_SPARE_C, 32'd42, 64'd7, 4'd1, 4'd1);
    endtask

    // Moves are the commonest beat, most between known frequencies, with reads in between;
    // loads keep coming until the table is full and then probe the full case.
    task automatic test_random();
        int          pick;
        logic [3:0]  row;
        logic [3:0]  col;
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            pick = $urandom_range(0, 99);
            row = 4'($urandom_range(0, 15));
            col = 4'($urandom_range(0, 15));
            if (pick < 12)
                send_beat(OP_LOAD, ($urandom_range(0, 3) == 0) ? pick_freq() : $urandom,
                          next_stamp(), row, col);
            else if (pick < 17)
                send_beat(OP_START, pick_freq(), next_stamp(), row, col);
            else if (pick < 60)
                send_beat(OP_MOVE, pick_freq(), next_stamp(), row, col);
            else if (pick < 78)
                send_beat(OP_READ_RES, $urandom, next_stamp(), row, col);
            else if (pick < 96)
                send_beat(OP_READ_CNT, $urandom, {$urandom, $urandom}, row, col);
            else
                send_beat(OP_W'($urandom_range(5, 7)), $urandom, {$urandom, $urandom},
                          row, col);
        end
    endtask

    initial begin
        for (int a = 0; a < NSTATES; a++) begin
            freq_tab[a] = '0;
            dwell_ticks[a] = '0;
            for (int b = 0; b < NSTATES; b++) switch_counts[a][b] = '0;
        end
        cur_state = 5'(UNKNOWN);
        last_stamp = '0;
        used_states = '0;
        change_count = '0;
        errors = 0;
        beats_sent = 0;
        results_seen = 0;
        cycles = 0;
        burst_left = 0;
        clock_ticks = 64'd2000;

        i_rst_n <= 1'b0;
        start <= 1'b0;
        i_operation <= OP_LOAD;
        i_freq_khz <= '0;
        i_now <= '0;
        i_from_index <= '0;
        i_to_index <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The block sweeps its memories after reset; send_beat simply waits
        // on busy until that is done.
        test_empty_table();
        test_load();
        test_moves();
        test_reads();
        test_unused_ops();
        test_random();

        start <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d command beats and checked %0d results.",
                 beats_sent, results_seen);
        $display("Table ended with %0d states and %0d recorded transitions.",
                 used_states, change_count);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: files.f
hdl/frs_pkg.sv
hdl/frs_ctrl.sv
hdl/frs_dpath.sv
hdl/frequency_residency_stats_top.sv
tb/frequency_residency_stats_top_test.sv
